// File: rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants of the morse stream decoder
// character codes, status codes, function codes and the front-to-back word
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int MaxSymbols   = 16;
    localparam int TableEntries = 64;
    localparam int CntW         = $clog2(MaxSymbols + 1);
    localparam int IdxW         = $clog2(TableEntries);
    localparam int QDepth       = 4;
    localparam int QPtrW        = $clog2(QDepth);

    localparam logic [7:0] ChSlash   = 8'h2F;
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChSpace   = 8'h20;

    localparam logic [1:0] FuncChar = 2'd0;
    localparam logic [1:0] FuncLoad = 2'd1;
    localparam logic [1:0] FuncEnd  = 2'd2;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StUnknown = 2'd1;
    localparam logic [1:0] StTooLong = 2'd2;
    localparam logic [1:0] StFull    = 2'd3;

    localparam logic [0:0] RegDot  = 1'd0;
    localparam logic [0:0] RegDash = 1'd1;

    typedef enum logic [1:0] {
        t_OP_EMIT,    // emit a fixed char/status
        t_OP_FLUSH,   // decode symbol, optionally followed by a fixed char
        t_OP_LOAD     // write table entry
    } t_op;

    // one word from front to back
    typedef struct packed {
        t_op              op;
        logic             tail;      // flush: emit fixed result after symbol
        logic [7:0]       ch;        // fixed char or load char
        logic [1:0]       st;        // fixed status
        logic             ovf;       // symbol overflowed
        logic [CntW-1:0]  len;       // symbol or load length
        logic [MaxSymbols-1:0] bits; // symbol or load code
    } t_cmd;

endpackage

// File: rtl/msd_front.sv
// ----------------------------------------------------------------------------
// msd_front: character classifier and symbol gatherer
// turns each accepted input word into at most one command for the back end
// ----------------------------------------------------------------------------
module msd_front
    import msd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_func,
    input  logic [7:0]        i_in_char,
    input  logic [7:0]        i_entry_char,
    input  logic [4:0]        i_entry_length,
    input  logic [15:0]       i_entry_bits,
    output logic              o_push,
    output t_cmd              o_cmd,
    input  logic              i_full
);
    logic [7:0]            r_dot, r_dash;
    logic [MaxSymbols-1:0] r_bits, n_bits;
    logic [CntW-1:0]       r_cnt, n_cnt;
    logic                  r_ovf, n_ovf, r_sep, n_sep;
    logic                  acc, pending;
    logic [MaxSymbols-1:0] mask;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;
    assign pending = (r_cnt != '0) || r_ovf;
    assign mask    = (i_entry_length >= 5'(MaxSymbols)) ? '1 :
                     MaxSymbols'((MaxSymbols+1)'(1) << i_entry_length) - 1'b1;

    always_comb begin
        n_bits = r_bits; n_cnt = r_cnt; n_ovf = r_ovf; n_sep = r_sep;
        o_push = 1'b0;
        o_cmd  = '{op: t_OP_EMIT, tail: 1'b0, ch: 8'd0, st: StOk, ovf: r_ovf,
                   len: r_cnt, bits: r_bits};
        case (i_func)
            FuncChar: begin
                if (i_in_char == ChSlash) begin
                    if (pending) begin
                        o_push = 1'b1; o_cmd.op = t_OP_FLUSH;
                        n_bits = '0; n_cnt = '0; n_ovf = 1'b0; n_sep = 1'b0;
                    end else if (!r_sep) begin
                        o_push = 1'b1; o_cmd.ch = ChSpace; n_sep = 1'b1;
                    end else begin
                        n_sep = 1'b0;
                    end
                end else if (i_in_char == ChNewline) begin
                    o_push = 1'b1; o_cmd.ch = ChNewline; n_sep = 1'b1;
                    if (pending) begin
                        o_cmd.op = t_OP_FLUSH; o_cmd.tail = 1'b1;
                        n_bits = '0; n_cnt = '0; n_ovf = 1'b0;
                    end
                end else if (i_in_char == r_dot || i_in_char == r_dash) begin
                    if (r_cnt < CntW'(MaxSymbols)) begin
                        n_bits[r_cnt[$clog2(MaxSymbols)-1:0]] = (i_in_char != r_dot);
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            FuncLoad: begin
                if (i_entry_length > 5'(MaxSymbols)) begin
                    o_push = 1'b1; o_cmd.st = StTooLong;
                end else if (i_entry_length != 5'd0) begin
                    o_push = 1'b1; o_cmd.op = t_OP_LOAD; o_cmd.ch = i_entry_char;
                    o_cmd.len = CntW'(i_entry_length);
                    o_cmd.bits = i_entry_bits & mask;
                end
            end
            FuncEnd: begin
                if (pending) begin
                    o_push = 1'b1; o_cmd.op = t_OP_FLUSH;
                    n_bits = '0; n_cnt = '0; n_ovf = 1'b0; n_sep = 1'b0;
                end
            end
            default: ;
        endcase
        if (!acc) o_push = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= 8'd46; r_dash <= 8'd45;
            r_bits <= '0; r_cnt <= '0; r_ovf <= 1'b0; r_sep <= 1'b1;
        end else begin
            if (i_cfg_we && i_cfg_idx == RegDot)  r_dot  <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == RegDash) r_dash <= i_cfg_data;
            if (acc) begin
                r_bits <= n_bits; r_cnt <= n_cnt; r_ovf <= n_ovf; r_sep <= n_sep;
            end
        end
    end
endmodule

// File: rtl/msd_queue.sv
// ----------------------------------------------------------------------------
// msd_queue: small command fifo between front and back
// ----------------------------------------------------------------------------
module msd_queue
    import msd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_cmd o_cmd
);
    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wp, r_rp;
    logic [QPtrW:0]   r_cnt;

    assign o_full  = r_cnt == (QPtrW+1)'(QDepth);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPtrW+1)'(i_push) - (QPtrW+1)'(i_pop);
        end
    end
endmodule

// File: rtl/msd_back.sv
// ----------------------------------------------------------------------------
// msd_back: code table and result generator
// parallel match against all entries, up to two result words per command
// ----------------------------------------------------------------------------
module msd_back
    import msd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_char,
    output logic [1:0]  o_status,
    output logic        o_last
);
    logic [7:0]            r_tch  [TableEntries];
    logic [CntW-1:0]       r_tlen [TableEntries];
    logic [MaxSymbols-1:0] r_tcod [TableEntries];
    logic [TableEntries-1:0] r_tval;
    logic                  r_second;   // first half of a flush+tail already sent
    logic                  r_valid;
    logic [7:0]            r_ch;
    logic [1:0]            r_st;
    logic                  r_last;

    logic [TableEntries-1:0] hit;
    logic [IdxW-1:0]       hit_idx, free_idx;
    logic [7:0]            hit_ch;
    logic                  any_hit, any_free, take, wr;
    logic [IdxW-1:0]       wr_idx;
    logic [7:0]            e_ch;
    logic [1:0]            e_st;
    logic                  e_last, emit, fin;

    always_comb begin
        hit_idx = '0; free_idx = '0; any_hit = 1'b0; any_free = 1'b0;
        hit_ch = 8'd0;
        for (int i = 0; i < TableEntries; i++) begin
            hit[i] = r_tval[i] && r_tlen[i] == i_cmd.len && r_tcod[i] == i_cmd.bits;
        end
        // codes are unique in the table, so at most one cell drives its char
        for (int i = 0; i < TableEntries; i++) begin
            hit_ch = hit_ch | (r_tch[i] & {8{hit[i]}});
        end
        for (int i = TableEntries - 1; i >= 0; i--) begin
            if (hit[i])     begin any_hit = 1'b1;  hit_idx = IdxW'(i); end
            if (!r_tval[i]) begin any_free = 1'b1; free_idx = IdxW'(i); end
        end
    end

    // a slot opens when the output register is empty or being taken
    assign take = !r_valid || !i_stall;

    always_comb begin
        e_ch = i_cmd.ch; e_st = i_cmd.st; e_last = 1'b1; emit = 1'b0; fin = 1'b0;
        wr = 1'b0; wr_idx = any_hit ? hit_idx : free_idx;
        case (i_cmd.op)
            t_OP_EMIT: begin emit = 1'b1; fin = 1'b1; end
            t_OP_FLUSH: begin
                emit = 1'b1;
                if (r_second) begin
                    fin = 1'b1;
                end else begin
                    e_last = !i_cmd.tail; fin = !i_cmd.tail;
                    e_ch = 8'd0; e_st = StUnknown;
                    if (i_cmd.ovf) e_st = StTooLong;
                    else if (any_hit) begin e_ch = hit_ch; e_st = StOk; end
                end
            end
            t_OP_LOAD: begin
                fin = 1'b1;
                if (any_hit || any_free) wr = 1'b1;
                else begin emit = 1'b1; e_ch = 8'd0; e_st = StFull; end
            end
            default: ;
        endcase
        if (i_empty || (emit && !take)) begin
            emit = 1'b0; fin = 1'b0; wr = 1'b0;
        end
    end

    assign o_pop = fin;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_tch[wr_idx] <= i_cmd.ch; r_tlen[wr_idx] <= i_cmd.len;
            r_tcod[wr_idx] <= i_cmd.bits;
        end
        if (emit) begin r_ch <= e_ch; r_st <= e_st; r_last <= e_last; end
        if (!i_rst_n) begin
            r_tval <= '0; r_second <= 1'b0; r_valid <= 1'b0;
        end else begin
            if (wr) r_tval[wr_idx] <= 1'b1;
            if (emit)      r_second <= !fin;
            if (emit)      r_valid <= 1'b1;
            else if (take) r_valid <= 1'b0;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_char = r_ch;
    assign o_status   = r_st;
    assign o_last     = r_last;
endmodule

// File: rtl/morse_stream_decoder.sv
// ----------------------------------------------------------------------------
// morse_stream_decoder: morse text stream to character decoder
// front gathers dots/dashes, back matches against a loaded code table
// ----------------------------------------------------------------------------
// path: a command is registered in the queue, then its result word in the output register
// throughput: one input word per cycle while o_stall is low; a newline after a symbol
//   gives two result words in the back end, absorbed by the four-deep command queue
// reset: synchronous active low; clears symbol state, table valid bits,
//   queue and output register, and restores dot '.' and dash '-'
module morse_stream_decoder
    import msd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // input words
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_in_char,
    input  logic [7:0]  i_entry_char,
    input  logic [4:0]  i_entry_length,
    input  logic [15:0] i_entry_bits,
    // result words
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_char,
    output logic [1:0]  o_status,
    output logic        o_last
);
    logic push, full, empty, pop;
    t_cmd cmd_in, cmd_out;

    // classifier and symbol gatherer
    msd_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_stall, .i_func, .i_in_char, .i_entry_char,
        .i_entry_length, .i_entry_bits,
        .o_push(push), .o_cmd(cmd_in), .i_full(full)
    );

    // decouples the two sides
    msd_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(cmd_in), .o_full(full),
        .o_empty(empty), .i_pop(pop), .o_cmd(cmd_out)
    );

    // table, matching and output register
    msd_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_cmd(cmd_out), .o_pop(pop),
        .o_valid, .i_stall, .o_out_char, .o_status, .o_last
    );
endmodule

// File: rtl/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker: port-level checks of the morse stream decoder
// ----------------------------------------------------------------------------
module msd_checker
    import msd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_char,
    input logic [1:0] o_status,
    input logic       o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_status))
        else $error("stalled result changed");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != StOk |-> o_out_char == 8'd0)
        else $error("error result with nonzero char");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == StFull || o_status == StTooLong) && o_out_char == 8'd0
        && !o_last |-> o_status == StTooLong)
        else $error("table full result not last");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind morse_stream_decoder msd_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_out_char, .o_status, .o_last
);
